### rtl/core/dsd_pkg.sv
`default_nettype none

package dsd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DIFF_W   = 23;

    // year + 399 keeps year zero positive; max 16383 + 399 fits in 15 bits
    localparam int T_W      = 15;
    localparam int T_OFFSET = 399;

    // serial day number, below 2^23 for every 14-bit year
    localparam int SERIAL_W = 23;
    // day-of-year part: cumulative months + day + leap day, max 366
    localparam int DOY_W    = 9;
    localparam int MIDX_W   = 4;
    localparam int CENT_W   = 8;

    // x / 100 as (x * 5243) >> 19, exact for x < 43690
    localparam int RECIP_W   = 13;
    localparam int RECIP_100 = 5243;
    localparam int RECIP_SH  = 19;
    localparam int TPROD_W   = T_W + RECIP_W;
    localparam int YPROD_W   = YEAR_W + RECIP_W;

    localparam int MONTH_COUNT = 12;
    localparam logic [MIDX_W-1:0] IDX_MARCH = MIDX_W'(2);

    localparam logic signed [DIFF_W-1:0] DIFF_MAX = {1'b0, {(DIFF_W-1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] DIFF_MIN = {1'b1, {(DIFF_W-1){1'b0}}};

    typedef logic [SERIAL_W-1:0] serial_t;

    // days in the months before month index m (0 = January)
    function automatic logic [DOY_W-1:0] days_before(input logic [MIDX_W-1:0] m);
        logic [DOY_W-1:0] r;
        begin
            case (m)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd59;
                4'd3:    r = 9'd90;
                4'd4:    r = 9'd120;
                4'd5:    r = 9'd151;
                4'd6:    r = 9'd181;
                4'd7:    r = 9'd212;
                4'd8:    r = 9'd243;
                4'd9:    r = 9'd273;
                4'd10:   r = 9'd304;
                default: r = 9'd334;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/dsd_date_serial.sv
`default_nettype none

// Three-stage serial day number of one date.
module dsd_date_serial
(
    input  wire logic                          clk,
    input  wire logic [dsd_pkg::YEAR_W-1:0]    year,
    input  wire logic [dsd_pkg::MONTH_W-1:0]   month,
    input  wire logic [dsd_pkg::DAY_W-1:0]     day,
    output dsd_pkg::serial_t                   serial
);

    // stage A: offset year, reciprocal products, clamped month
    logic [dsd_pkg::T_W-1:0]      t_reg;
    logic [dsd_pkg::YEAR_W-1:0]   y_reg;
    logic [dsd_pkg::TPROD_W-1:0]  tprod_reg;
    logic [dsd_pkg::YPROD_W-1:0]  yprod_reg;
    logic [dsd_pkg::MIDX_W-1:0]   midx_reg;
    logic [dsd_pkg::DAY_W-1:0]    day_a_reg;

    logic [dsd_pkg::T_W-1:0]      t_next;
    logic [dsd_pkg::MIDX_W-1:0]   midx_next;

    always_comb
    begin
        t_next = dsd_pkg::T_W'(year) + dsd_pkg::T_W'(dsd_pkg::T_OFFSET);
        if (month == '0)
        begin
            midx_next = '0;
        end
        else if (month > dsd_pkg::MONTH_W'(dsd_pkg::MONTH_COUNT))
        begin
            midx_next = dsd_pkg::MIDX_W'(dsd_pkg::MONTH_COUNT - 1);
        end
        else
        begin
            midx_next = month - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        y_reg     <= year;
        tprod_reg <= dsd_pkg::TPROD_W'(t_next) * dsd_pkg::TPROD_W'(dsd_pkg::RECIP_100);
        yprod_reg <= dsd_pkg::YPROD_W'(year) * dsd_pkg::YPROD_W'(dsd_pkg::RECIP_100);
        midx_reg  <= midx_next;
        day_a_reg <= day;
    end

    // stage B: whole-year days and day-of-year
    logic [dsd_pkg::CENT_W-1:0]   qt;
    logic [dsd_pkg::CENT_W-1:0]   qy;
    logic [dsd_pkg::YEAR_W-1:0]   y_cent;
    logic                         div100;
    logic                         leap;
    logic [dsd_pkg::SERIAL_W-1:0] base_next;
    logic [dsd_pkg::DOY_W-1:0]    doy_next;
    logic [dsd_pkg::SERIAL_W-1:0] base_reg;
    logic [dsd_pkg::DOY_W-1:0]    doy_reg;

    always_comb
    begin
        qt     = tprod_reg[dsd_pkg::RECIP_SH +: dsd_pkg::CENT_W];
        qy     = yprod_reg[dsd_pkg::RECIP_SH +: dsd_pkg::CENT_W];
        y_cent = dsd_pkg::YEAR_W'(qy) * dsd_pkg::YEAR_W'(100);
        div100 = (y_cent == y_reg);
        leap   = ((y_reg[1:0] == 2'b00) && !div100) || (div100 && (qy[1:0] == 2'b00));
        base_next = dsd_pkg::SERIAL_W'(t_reg) * dsd_pkg::SERIAL_W'(365)
                  + dsd_pkg::SERIAL_W'(t_reg >> 2)
                  - dsd_pkg::SERIAL_W'(qt)
                  + dsd_pkg::SERIAL_W'(qt >> 2);
        doy_next  = dsd_pkg::days_before(midx_reg)
                  + dsd_pkg::DOY_W'(day_a_reg)
                  + dsd_pkg::DOY_W'(leap && (midx_reg >= dsd_pkg::IDX_MARCH));
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        doy_reg  <= doy_next;
    end

    // stage C: serial sum
    dsd_pkg::serial_t serial_reg;

    always_ff @(posedge clk)
    begin
        serial_reg <= base_reg + dsd_pkg::SERIAL_W'(doy_reg);
    end

    assign serial = serial_reg;

endmodule

`default_nettype wire

### rtl/core/dsd_diff.sv
`default_nettype none

// End minus start, saturated to the output width, registered.
module dsd_diff
(
    input  wire logic                              clk,
    input  wire dsd_pkg::serial_t                  start_serial,
    input  wire dsd_pkg::serial_t                  end_serial,
    output logic signed [dsd_pkg::DIFF_W-1:0]      diff
);

    logic signed [dsd_pkg::SERIAL_W:0]    wide;
    logic signed [dsd_pkg::DIFF_W-1:0]    diff_next;
    logic signed [dsd_pkg::DIFF_W-1:0]    diff_reg;

    always_comb
    begin
        wide = $signed({1'b0, end_serial}) - $signed({1'b0, start_serial});
        if (wide > (dsd_pkg::SERIAL_W+1)'(dsd_pkg::DIFF_MAX))
        begin
            diff_next = dsd_pkg::DIFF_MAX;
        end
        else if (wide < (dsd_pkg::SERIAL_W+1)'(dsd_pkg::DIFF_MIN))
        begin
            diff_next = dsd_pkg::DIFF_MIN;
        end
        else
        begin
            diff_next = wide[dsd_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign diff = diff_reg;

endmodule

`default_nettype wire

### rtl/core/date_span_days.sv
// Pipeline: a transaction accepted on start passes three serial-number stages and one
//   subtract/saturate stage; done marks the cycle in which its result is on the port.
// Throughput: one transaction per cycle; busy is tied low, the pipeline never stalls.
// The receiver cannot stall: done is a one-cycle strobe and the result is gone after it.
// Reset: rst_n (async, active low) clears the valid pipeline only; datapath registers
//   carry no reset, so done stays low until a fresh transaction has passed through.
`default_nettype none

module date_span_days
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [dsd_pkg::YEAR_W-1:0]            start_year,
    input  wire logic [dsd_pkg::MONTH_W-1:0]           start_month,
    input  wire logic [dsd_pkg::DAY_W-1:0]             start_day,
    input  wire logic [dsd_pkg::YEAR_W-1:0]            end_year,
    input  wire logic [dsd_pkg::MONTH_W-1:0]           end_month,
    input  wire logic [dsd_pkg::DAY_W-1:0]             end_day,
    output logic                                       done,
    output logic signed [dsd_pkg::DIFF_W-1:0]          day_difference
);

    // Number of register stages from inputs to result port.
    localparam int STAGES = 4;

    // Fully pipelined, no back-pressure: never busy.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits walk alongside the datapath; one bit per stage.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Serial day numbers for both dates; the constant offset cancels in the difference.
    dsd_pkg::serial_t start_serial;
    dsd_pkg::serial_t end_serial;

    dsd_date_serial u_start_serial
    (
        .clk    (clk),
        .year   (start_year),
        .month  (start_month),
        .day    (start_day),
        .serial (start_serial)
    );

    dsd_date_serial u_end_serial
    (
        .clk    (clk),
        .year   (end_year),
        .month  (end_month),
        .day    (end_day),
        .serial (end_serial)
    );

    // Final stage: signed difference, clamped to the port width.
    dsd_diff u_diff
    (
        .clk          (clk),
        .start_serial (start_serial),
        .end_serial   (end_serial),
        .diff         (day_difference)
    );

    assign done = valid_reg[STAGES-1];

endmodule

`default_nettype wire

### rtl/core/dsd_checker.sv
`default_nettype none

module dsd_checker
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic                                  busy,
    input  wire logic [dsd_pkg::YEAR_W-1:0]            start_year,
    input  wire logic [dsd_pkg::MONTH_W-1:0]           start_month,
    input  wire logic [dsd_pkg::DAY_W-1:0]             start_day,
    input  wire logic [dsd_pkg::YEAR_W-1:0]            end_year,
    input  wire logic [dsd_pkg::MONTH_W-1:0]           end_month,
    input  wire logic [dsd_pkg::DAY_W-1:0]             end_day,
    input  wire logic                                  done,
    input  wire logic signed [dsd_pkg::DIFF_W-1:0]     day_difference
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result missing after accepted transaction");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without transaction");

    a_same_date: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (start_year == end_year) && (start_month == end_month)
         && (start_day == end_day)) |-> ##4 (day_difference == '0))
        else $error("equal dates gave non-zero span");

endmodule

bind date_span_days dsd_checker u_dsd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .start_year     (start_year),
    .start_month    (start_month),
    .start_day      (start_day),
    .end_year       (end_year),
    .end_month      (end_month),
    .end_day        (end_day),
    .done           (done),
    .day_difference (day_difference)
);

`default_nettype wire

### sim/tb_date_span_days.sv
`timescale 1ns / 1ps

// Checks date_span_days against its own day-count predictor.
// A queue of date pairs is filled up front (directed corners, then random pairs).
// The driver sends them in bursts with random gaps and changes inputs on the falling edge.
// The monitor samples on the rising edge. It records an expected span for every accepted
// transaction and compares each done strobe with the oldest expected span.
module tb_date_span_days;

    // one queued date pair; hold_for_idle makes the driver wait until the pipe is empty
    typedef struct {
        logic [dsd_pkg::YEAR_W-1:0]  start_year;
        logic [dsd_pkg::MONTH_W-1:0] start_month;
        logic [dsd_pkg::DAY_W-1:0]   start_day;
        logic [dsd_pkg::YEAR_W-1:0]  end_year;
        logic [dsd_pkg::MONTH_W-1:0] end_month;
        logic [dsd_pkg::DAY_W-1:0]   end_day;
        bit                          hold_for_idle;
    } date_pair_t;

    // days in the months before month index i, January = 0
    localparam int unsigned MONTH_START_DAY [dsd_pkg::MONTH_COUNT] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    localparam int RANDOM_PAIRS = 650;
    localparam int TAIL_CYCLES  = 12;     // pipeline is 4 deep; a little margin

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [dsd_pkg::YEAR_W-1:0]        start_year = '0;
    logic [dsd_pkg::MONTH_W-1:0]       start_month = '0;
    logic [dsd_pkg::DAY_W-1:0]         start_day = '0;
    logic [dsd_pkg::YEAR_W-1:0]        end_year = '0;
    logic [dsd_pkg::MONTH_W-1:0]       end_month = '0;
    logic [dsd_pkg::DAY_W-1:0]         end_day = '0;
    logic                              done;
    logic signed [dsd_pkg::DIFF_W-1:0] day_difference;

    date_pair_t                        date_pair_q[$];
    logic signed [dsd_pkg::DIFF_W-1:0] span_expected_q[$];
    logic                              taken = 1'b0;   // accepted at the last rising edge
    int                                burst_left = 4;
    int                                gap_left = 0;
    int                                fail_count = 0;

    date_span_days uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .start_year     (start_year),
        .start_month    (start_month),
        .start_day      (start_day),
        .end_year       (end_year),
        .end_month      (end_month),
        .end_day        (end_day),
        .done           (done),
        .day_difference (day_difference)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Serial day number with a fixed offset that cancels in the difference.
    // Out-of-range months clamp to January/December, days count on linearly,
    // and year zero is a leap year, exactly as the block is meant to behave.
    function automatic longint day_serial(input logic [dsd_pkg::YEAR_W-1:0] y,
                                          input logic [dsd_pkg::MONTH_W-1:0] m,
                                          input logic [dsd_pkg::DAY_W-1:0] d);
        longint t;
        longint n;
        int     idx;
        bit     leap;
        begin
            t = longint'(y) + 399;
            if (m == 0)
                idx = 0;
            else if (m > dsd_pkg::MONTH_COUNT)
                idx = dsd_pkg::MONTH_COUNT - 1;
            else
                idx = int'(m) - 1;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            n = 365 * t + t / 4 - t / 100 + t / 400 + MONTH_START_DAY[idx] + d;
            if (idx >= 2 && leap)
                n = n + 1;
            return n;
        end
    endfunction

    // end serial minus start serial, clipped to the 23-bit output range
    function automatic logic signed [dsd_pkg::DIFF_W-1:0] predict_span(input date_pair_t p);
        longint span;
        begin
            span = day_serial(p.end_year, p.end_month, p.end_day)
                 - day_serial(p.start_year, p.start_month, p.start_day);
            if (span > longint'(dsd_pkg::DIFF_MAX))
                span = longint'(dsd_pkg::DIFF_MAX);
            if (span < longint'(dsd_pkg::DIFF_MIN))
                span = longint'(dsd_pkg::DIFF_MIN);
            return dsd_pkg::DIFF_W'(span);
        end
    endfunction

    function automatic int month_length(input int y, input int m);
        bit leap;
        begin
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (m)
                2:             return leap ? 29 : 28;
                4, 6, 9, 11:   return 30;
                default:       return 31;
            endcase
        end
    endfunction

    task automatic queue_pair(input int sy, input int sm, input int sd,
                              input int ey, input int em, input int ed,
                              input bit hold);
        date_pair_t p;
        begin
            p.start_year    = dsd_pkg::YEAR_W'(sy);
            p.start_month   = dsd_pkg::MONTH_W'(sm);
            p.start_day     = dsd_pkg::DAY_W'(sd);
            p.end_year      = dsd_pkg::YEAR_W'(ey);
            p.end_month     = dsd_pkg::MONTH_W'(em);
            p.end_day       = dsd_pkg::DAY_W'(ed);
            p.hold_for_idle = hold;
            date_pair_q.push_back(p);
        end
    endtask

    // Driver: falling edge. A pair stays on the ports until it has been taken;
    // then the next one goes out, unless the sender is in a gap between bursts
    // or the next pair asks for an empty pipeline first.
    always @(negedge clk)
    begin
        date_pair_t nxt;
        logic       send;
        send = 1'b0;
        if (rst_n && !(start && !taken))
        begin
            if (gap_left > 0)
                gap_left--;
            else if (date_pair_q.size() != 0 &&
                     !(date_pair_q[0].hold_for_idle && span_expected_q.size() != 0))
            begin
                nxt  = date_pair_q.pop_front();
                send = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    // a quarter of bursts run straight on into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        if (rst_n && start && !taken)
            start <= 1'b1;      // still waiting for acceptance, hold everything
        else
            start <= send;
        if (send)
        begin
            start_year  <= nxt.start_year;
            start_month <= nxt.start_month;
            start_day   <= nxt.start_day;
            end_year    <= nxt.end_year;
            end_month   <= nxt.end_month;
            end_day     <= nxt.end_day;
        end
    end

    // Monitor: rising edge. Check the strobe first, then log any new transaction.
    always @(posedge clk or negedge rst_n)
    begin
        date_pair_t                        seen;
        logic signed [dsd_pkg::DIFF_W-1:0] want;
        if (!rst_n)
        begin
            taken <= 1'b0;
        end
        else
        begin
            taken <= start && !busy;
            if (done === 1'b1)
            begin
                if (span_expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: day_difference expected none, got %0d",
                             $time, day_difference);
                end
                else
                begin
                    want = span_expected_q.pop_front();
                    if (day_difference !== want)
                    begin
                        fail_count++;
                        $display("%0t: day_difference expected %0d, got %0d",
                                 $time, want, day_difference);
                    end
                end
            end
            else if (done !== 1'b0)
            begin
                fail_count++;
                $display("%0t: done expected 0 or 1, got %b", $time, done);
            end
            if (start && !busy)
            begin
                seen.start_year  = start_year;
                seen.start_month = start_month;
                seen.start_day   = start_day;
                seen.end_year    = end_year;
                seen.end_month   = end_month;
                seen.end_day     = end_day;
                seen.hold_for_idle = 1'b0;
                span_expected_q.push_back(predict_span(seen));
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int sy;
        int sm;
        int sd;
        int ey;
        int em;
        int ed;
        int kind;

        // directed corners
        queue_pair(2000, 1, 1, 2000, 1, 1, 1'b1);         // same date
        queue_pair(1, 1, 1, 9999, 12, 31, 1'b0);          // widest valid span
        queue_pair(9999, 12, 31, 1, 1, 1, 1'b0);          // and reversed
        queue_pair(2024, 1, 1, 2023, 12, 31, 1'b0);       // end a year earlier
        queue_pair(2000, 2, 28, 2000, 3, 1, 1'b0);        // 400-year leap
        queue_pair(1900, 2, 28, 1900, 3, 1, 1'b0);        // century, not leap
        queue_pair(2004, 2, 29, 2005, 3, 1, 1'b0);
        queue_pair(2020, 0, 5, 2020, 1, 5, 1'b0);         // month zero reads as January
        queue_pair(2020, 15, 31, 2020, 12, 31, 1'b0);     // month above twelve reads as December
        queue_pair(2021, 3, 0, 2021, 2, 28, 1'b0);        // day zero is end of previous month
        queue_pair(2021, 4, 31, 2021, 5, 1, 1'b0);        // day past month end rolls on
        queue_pair(0, 3, 1, 0, 2, 28, 1'b0);              // year zero is leap
        queue_pair(0, 1, 1, 1, 1, 1, 1'b0);
        queue_pair(16383, 12, 31, 9999, 12, 31, 1'b0);    // beyond 9999
        queue_pair(0, 0, 0, 16383, 15, 31, 1'b1);         // clips high
        queue_pair(16383, 15, 31, 0, 0, 0, 1'b0);         // clips low
        queue_pair(0, 0, 0, 0, 0, 0, 1'b0);               // all bits clear
        queue_pair(16383, 15, 31, 16383, 15, 31, 1'b0);   // all bits set
        queue_pair(1, 1, 1, 11486, 1, 1, 1'b0);           // just over the upper clip
        queue_pair(11486, 1, 1, 1, 1, 1, 1'b0);
        queue_pair(1999, 12, 31, 2000, 1, 1, 1'b0);

        // random pairs: mostly valid dates, some near each other, some raw bits
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                sy = $urandom_range(1, 9999);
                sm = $urandom_range(1, 12);
                sd = $urandom_range(1, month_length(sy, sm));
                if (kind <= 3)
                    ey = $urandom_range(1, 9999);
                else
                begin
                    ey = sy + $urandom_range(0, 4) - 2;
                    if (ey < 1)
                        ey = 1;
                    if (ey > 9999)
                        ey = 9999;
                end
                em = $urandom_range(1, 12);
                ed = $urandom_range(1, month_length(ey, em));
            end
            else if (kind <= 8)
            begin
                sy = $urandom_range(0, 16383);
                sm = $urandom_range(0, 15);
                sd = $urandom_range(0, 31);
                ey = $urandom_range(0, 16383);
                em = $urandom_range(0, 15);
                ed = $urandom_range(0, 31);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       sy = 0;
                    1:       sy = 16383;
                    2:       sy = 9999;
                    default: sy = $urandom_range(1, 9999);
                endcase
                case ($urandom_range(0, 3))
                    0:       ey = 0;
                    1:       ey = 16383;
                    2:       ey = 1;
                    default: ey = $urandom_range(1, 9999);
                endcase
                sm = $urandom_range(0, 15);
                sd = $urandom_range(0, 31);
                em = $urandom_range(0, 15);
                ed = $urandom_range(0, 31);
            end
            queue_pair(sy, sm, sd, ey, em, ed, (i == 0) || ($urandom_range(0, 99) == 0));
        end

        // reset held from time zero, released clear of both clock edges
        repeat (5) @(posedge clk);
        #1 rst_n = 1'b1;

        while (date_pair_q.size() != 0 || start)
            @(posedge clk);
        while (span_expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hard limit, far beyond the slowest legitimate run
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
